>>> rtl/lmrd_pkg.sv
// lmrd_pkg: shared widths, codes, result record and marker helpers
// for the length-marked record deframer
// no dependencies
package lmrd_pkg;

  // reported length width and the saturation width of the length field
  localparam int LEN_W       = 31;
  localparam int LENGTH_BITS = 31;
  localparam int MARK_W      = 64;
  localparam int CNT_W       = 3;

  // configuration register indexes
  localparam logic [1:0] CFG_MARKER_MODE = 2'd0;
  localparam logic [1:0] CFG_MARKER_SWAP = 2'd1;
  localparam logic [1:0] CFG_MAX_RECORD  = 2'd2;

  // marker modes (upper bit set means no markers)
  localparam logic [1:0] MODE_FOUR  = 2'd0;
  localparam logic [1:0] MODE_EIGHT = 2'd1;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_TRUNC   = 2'd2;

  // end status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;

  // framer phases
  localparam logic [1:0] PH_HEAD = 2'd0;
  localparam logic [1:0] PH_PAY  = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;
  localparam logic [1:0] PH_HALT = 2'd3;

  localparam logic [LEN_W-1:0] MAX_RECORD_RESET = LEN_W'(10000);

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       data;
    logic [LEN_W-1:0] length;
    logic [1:0]       status;
    logic             last;
  } result_t;

  // saturate a marker value to the length field and cut to the port width
  function automatic logic [LEN_W-1:0] len_report(input logic [MARK_W-1:0] v);
    logic [MARK_W-1:0] lim;
    lim = {MARK_W{1'b1}} >> (MARK_W - LENGTH_BITS);
    if (v > lim) begin
      return lim[LEN_W-1:0];
    end
    return v[LEN_W-1:0];
  endfunction

  // accumulate one marker byte, little-endian or byte-swapped
  function automatic logic [MARK_W-1:0] shift_in(input logic [MARK_W-1:0] acc,
                                                 input logic [CNT_W-1:0]  cnt,
                                                 input logic [7:0]        b,
                                                 input logic              swap);
    logic [MARK_W-1:0] wide;
    wide = {{(MARK_W-8){1'b0}}, b};
    if (swap) begin
      return {acc[MARK_W-9:0], b};
    end
    return acc | (wide << {cnt, 3'b000});
  endfunction

endpackage

>>> rtl/length_marked_record_deframer_core.sv
// length_marked_record_deframer_core: top level of the record deframer
// strips length markers from a byte stream, emits payload bytes and record ends
// depends on lmrd_pkg
//
//  channel | direction | transfer when          | carries
//  --------+-----------+------------------------+---------------------------------------
//  in      | sink      | in_valid & in_ready    | stream_byte, stream_end
//  out     | source    | out_valid & out_ready  | result_kind, payload_byte,
//          |           |                        | record_length, end_status, run_last
//  cfg     | sink      | cfg_valid & cfg_ready  | cfg_index, cfg_data (cfg_ready is 1)
//
// one input byte per cycle while out_ready is high; a byte that yields two results
// (payload plus record end) holds the next byte while the result register drains
// a byte is taken into the input register, evaluated into the two-entry result
// register once that can load, and shown on out from there
// rst (synchronous) clears the framer to the header phase and restores register defaults
// a stalled out side fills the result register and then the input register,
// after which in_ready drops
module length_marked_record_deframer_core (
  input  logic                        clk,
  input  logic                        rst,
  // input stream
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  stream_byte,
  input  logic                        stream_end,
  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  result_kind,
  output logic [7:0]                  payload_byte,
  output logic [lmrd_pkg::LEN_W-1:0]  record_length,
  output logic [1:0]                  end_status,
  output logic                        run_last,
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [lmrd_pkg::LEN_W-1:0]  cfg_data
);

  // configuration registers
  logic [1:0]                   marker_mode;
  logic                         marker_swap;
  logic [lmrd_pkg::LEN_W-1:0]   max_record_bytes;

  // framer state
  logic [1:0]                   phase, phase_next;
  logic [lmrd_pkg::CNT_W-1:0]   marker_byte_count, cnt_next;
  logic [lmrd_pkg::MARK_W-1:0]  head_marker, head_next;
  logic [lmrd_pkg::MARK_W-1:0]  tail_marker, tail_next;
  logic [lmrd_pkg::LEN_W-1:0]   payload_left, left_next;

  // input register
  logic                         in_full;
  logic [7:0]                   in_byte;
  logic                         in_end;

  // result register
  lmrd_pkg::result_t            slot0, slot1;
  logic [1:0]                   res_cnt;

  // evaluation outputs
  lmrd_pkg::result_t            res_a, res_b;
  logic [1:0]                   res_n;
  logic                         no_marker;
  logic                         marker_done;
  logic [lmrd_pkg::MARK_W-1:0]  shifted;
  logic [lmrd_pkg::LEN_W-1:0]   nm_len;
  logic [lmrd_pkg::LEN_W-1:0]   left_dec;
  lmrd_pkg::result_t            trunc_res;

  logic                         can_load;
  logic                         fire;
  logic                         out_xfer;

  // handshake
  assign cfg_ready = 1'b1;
  assign out_valid = (res_cnt != 2'd0);
  assign out_xfer  = out_valid && out_ready;
  assign can_load  = (res_cnt == 2'd0) || ((res_cnt == 2'd1) && out_ready);
  assign fire      = in_full && can_load;
  assign in_ready  = !in_full || fire;

  assign no_marker = marker_mode[1];
  assign nm_len    = (max_record_bytes == '0) ? lmrd_pkg::LEN_W'(1) : max_record_bytes;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      marker_mode      <= lmrd_pkg::MODE_FOUR;
      marker_swap      <= 1'b0;
      max_record_bytes <= lmrd_pkg::MAX_RECORD_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lmrd_pkg::CFG_MARKER_MODE: marker_mode      <= cfg_data[1:0];
        lmrd_pkg::CFG_MARKER_SWAP: marker_swap      <= cfg_data[0];
        lmrd_pkg::CFG_MAX_RECORD:  max_record_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
    if (in_valid && in_ready) begin
      in_byte <= stream_byte;
      in_end  <= stream_end;
    end
  end

  // one byte through the framer: next state and up to two results
  always_comb begin
    phase_next  = phase;
    cnt_next    = marker_byte_count;
    head_next   = head_marker;
    tail_next   = tail_marker;
    left_next   = payload_left;
    res_a       = '0;
    res_b       = '0;
    res_n       = 2'd0;
    shifted     = '0;
    marker_done = 1'b0;
    left_dec    = '0;
    trunc_res   = '0;
    if (phase != lmrd_pkg::PH_HALT) begin
      // no-marker mode opens a full-length record at once
      if (no_marker && phase != lmrd_pkg::PH_PAY) begin
        head_next  = {{(lmrd_pkg::MARK_W-lmrd_pkg::LEN_W){1'b0}}, nm_len};
        left_next  = nm_len;
        cnt_next   = '0;
        phase_next = lmrd_pkg::PH_PAY;
      end
      marker_done = (marker_mode == lmrd_pkg::MODE_EIGHT) ?
                    (cnt_next == lmrd_pkg::CNT_W'(7)) : (cnt_next >= lmrd_pkg::CNT_W'(3));
      unique case (phase_next)
        lmrd_pkg::PH_HEAD: begin
          shifted   = lmrd_pkg::shift_in(head_next, cnt_next, in_byte, marker_swap);
          head_next = shifted;
          if (marker_done) begin
            cnt_next  = '0;
            tail_next = '0;
            if (shifted > {{(lmrd_pkg::MARK_W-lmrd_pkg::LEN_W){1'b0}}, max_record_bytes}) begin
              res_a.kind   = lmrd_pkg::KIND_END;
              res_a.length = lmrd_pkg::len_report(shifted);
              res_a.status = lmrd_pkg::ST_TOO_LONG;
              res_n        = 2'd1;
              phase_next   = lmrd_pkg::PH_HALT;
            end else if (shifted == '0) begin
              phase_next = lmrd_pkg::PH_TAIL;
            end else begin
              left_next  = shifted[lmrd_pkg::LEN_W-1:0];
              phase_next = lmrd_pkg::PH_PAY;
            end
          end else begin
            cnt_next = cnt_next + lmrd_pkg::CNT_W'(1);
          end
        end
        lmrd_pkg::PH_TAIL: begin
          shifted   = lmrd_pkg::shift_in(tail_next, cnt_next, in_byte, marker_swap);
          tail_next = shifted;
          if (marker_done) begin
            res_a.kind   = lmrd_pkg::KIND_END;
            res_a.length = lmrd_pkg::len_report(head_next);
            res_a.status = (shifted == head_next) ? lmrd_pkg::ST_OK : lmrd_pkg::ST_MISMATCH;
            res_n        = 2'd1;
            phase_next   = lmrd_pkg::PH_HEAD;
            cnt_next     = '0;
            head_next    = '0;
            tail_next    = '0;
            left_next    = '0;
          end else begin
            cnt_next = cnt_next + lmrd_pkg::CNT_W'(1);
          end
        end
        lmrd_pkg::PH_PAY: begin
          res_a.kind = lmrd_pkg::KIND_PAYLOAD;
          res_a.data = in_byte;
          res_n      = 2'd1;
          left_dec   = (left_next == '0) ? '0 : left_next - lmrd_pkg::LEN_W'(1);
          left_next  = left_dec;
          if (left_dec == '0) begin
            if (no_marker) begin
              res_b.kind   = lmrd_pkg::KIND_END;
              res_b.length = lmrd_pkg::len_report(head_next);
              res_b.status = lmrd_pkg::ST_OK;
              res_n        = 2'd2;
              phase_next   = lmrd_pkg::PH_HEAD;
              cnt_next     = '0;
              head_next    = '0;
              tail_next    = '0;
              left_next    = '0;
            end else begin
              phase_next = lmrd_pkg::PH_TAIL;
              cnt_next   = '0;
              tail_next  = '0;
            end
          end
        end
        default: ;
      endcase
      // stream ends inside an open record
      if (in_end && phase_next != lmrd_pkg::PH_HALT &&
          !(phase_next == lmrd_pkg::PH_HEAD && cnt_next == '0)) begin
        trunc_res.kind   = lmrd_pkg::KIND_TRUNC;
        trunc_res.length = (phase_next == lmrd_pkg::PH_HEAD) ? '0 :
                           lmrd_pkg::len_report(head_next);
        if (res_n == 2'd0) begin
          res_a = trunc_res;
        end else begin
          res_b = trunc_res;
        end
        res_n      = res_n + 2'd1;
        phase_next = lmrd_pkg::PH_HEAD;
        cnt_next   = '0;
        head_next  = '0;
        tail_next  = '0;
        left_next  = '0;
      end
      // mark the last result of this byte
      if (res_n == 2'd1) begin
        res_a.last = 1'b1;
      end else if (res_n == 2'd2) begin
        res_b.last = 1'b1;
      end
    end
  end

  // framer state update
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= lmrd_pkg::PH_HEAD;
      marker_byte_count <= '0;
      head_marker       <= '0;
      tail_marker       <= '0;
      payload_left      <= '0;
    end else if (fire) begin
      phase             <= phase_next;
      marker_byte_count <= cnt_next;
      head_marker       <= head_next;
      tail_marker       <= tail_next;
      payload_left      <= left_next;
    end
  end

  // result register: two entries, slot0 is shown
  always_ff @(posedge clk) begin
    if (rst) begin
      res_cnt <= 2'd0;
    end else if (fire) begin
      slot0   <= res_a;
      slot1   <= res_b;
      res_cnt <= res_n;
    end else if (out_xfer) begin
      slot0   <= slot1;
      res_cnt <= res_cnt - 2'd1;
    end
  end

  // result ports
  assign result_kind   = slot0.kind;
  assign payload_byte  = slot0.data;
  assign record_length = slot0.length;
  assign end_status    = slot0.status;
  assign run_last      = slot0.last;

endmodule

>>> rtl/lmrd_checker.sv
// lmrd_checker: port-level assertions for the record deframer, bound to the top level
// depends on lmrd_pkg and length_marked_record_deframer_core
module lmrd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  result_kind,
  input logic [7:0]                  payload_byte,
  input logic [lmrd_pkg::LEN_W-1:0]  record_length,
  input logic [1:0]                  end_status,
  input logic                        run_last
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
      $stable(payload_byte) && $stable(record_length) && $stable(end_status) &&
      $stable(run_last))
    else $error("stalled result changed");

  // input is only back-pressured while a result waits
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // a record end or truncation always closes the results of its byte
  assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind != lmrd_pkg::KIND_PAYLOAD |-> run_last)
    else $error("record end not last of its run");

  // after a too-long end the framer halts and nothing follows
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && result_kind == lmrd_pkg::KIND_END &&
      end_status == lmrd_pkg::ST_TOO_LONG |=> !out_valid)
    else $error("result after too-long end");

endmodule

bind length_marked_record_deframer_core lmrd_checker u_lmrd_checker (.*);
